/* rtl/core/bqsat_pkg.sv */
// Shared types and constants of the box versus quadrilateral separating-axis test.
`timescale 1ns / 1ps

package bqsat_pkg;

  localparam int VERTEX_COUNT = 4;
  localparam int AXIS_COUNT   = 2 * VERTEX_COUNT;
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = DIFF_W + COORD_W;
  localparam int DOT_W        = PROD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  // Corners of both shapes in perimeter order
  typedef struct {
    coord_t px [VERTEX_COUNT];
    coord_t py [VERTEX_COUNT];
    coord_t qx [VERTEX_COUNT];
    coord_t qy [VERTEX_COUNT];
  } corners_t;

  // Axis component times corner coordinate, per axis and corner
  typedef struct {
    prod_t px [AXIS_COUNT][VERTEX_COUNT];
    prod_t py [AXIS_COUNT][VERTEX_COUNT];
    prod_t qx [AXIS_COUNT][VERTEX_COUNT];
    prod_t qy [AXIS_COUNT][VERTEX_COUNT];
  } prod_set_t;

endpackage

/* rtl/core/bqsat_in_if.sv */
// Input channel: one box and one quadrilateral per beat.
`timescale 1ns / 1ps

interface bqsat_in_if;
  logic            valid;
  logic            ready;
  bqsat_pkg::coord_t box_left;
  bqsat_pkg::coord_t box_top;
  bqsat_pkg::coord_t box_right;
  bqsat_pkg::coord_t box_bottom;
  bqsat_pkg::coord_t quad_x0;
  bqsat_pkg::coord_t quad_y0;
  bqsat_pkg::coord_t quad_x1;
  bqsat_pkg::coord_t quad_y1;
  bqsat_pkg::coord_t quad_x2;
  bqsat_pkg::coord_t quad_y2;
  bqsat_pkg::coord_t quad_x3;
  bqsat_pkg::coord_t quad_y3;

  modport source (
    output valid, box_left, box_top, box_right, box_bottom,
    output quad_x0, quad_y0, quad_x1, quad_y1, quad_x2, quad_y2, quad_x3, quad_y3,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_top, box_right, box_bottom,
    input  quad_x0, quad_y0, quad_x1, quad_y1, quad_x2, quad_y2, quad_x3, quad_y3,
    output ready
  );
endinterface

/* rtl/core/bqsat_out_if.sv */
// Result channel: one intersection flag per beat.
`timescale 1ns / 1ps

interface bqsat_out_if;
  logic valid;
  logic ready;
  logic intersects;

  modport source (output valid, intersects, input ready);
  modport sink (input valid, intersects, output ready);
endinterface

/* rtl/core/box_quad_separating_axis_test_top.sv */
// Top level of the box versus convex quadrilateral separating-axis test.
`timescale 1ns / 1ps

// Each beat on in_ch carries an axis-aligned box and the four corners of a
// quadrilateral (corners listed left-top, right-top, left-bottom, right-bottom,
// walked in perimeter order 0,1,3,2); out_ch returns one intersects flag per
// beat, in order. Touching shapes count as intersecting. The block takes one
// item every cycle while out_ch.ready stays high. Each item passes through
// an input register, a register after the edge-normal multipliers, and the
// result register after the range compare, which drives out_ch. Up to three
// items are in flight, so in_ch.ready stays high while a stalled result waits
// and a stage is free.
module box_quad_separating_axis_test_top (
  input  logic           clk,
  input  logic           rst_n,
  bqsat_in_if.sink       in_ch,
  bqsat_out_if.source    out_ch
);

  logic                 s0_vld_r;
  logic                 s1_vld_r;
  logic                 out_vld_r;
  logic                 out_int_r;
  bqsat_pkg::corners_t  s0_corners_r;
  bqsat_pkg::prod_set_t s1_prods_r;
  bqsat_pkg::prod_set_t prods_nxt;
  logic                 int_nxt;
  logic                 out_load;
  logic                 s1_load;
  logic                 s0_load;

  // Advance each stage when it is empty or its contents move on
  assign out_load    = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign s1_load     = s0_vld_r && (!s1_vld_r || out_load);
  assign in_ch.ready = !s0_vld_r || s1_load;
  assign s0_load     = in_ch.valid && in_ch.ready;

  // Hold stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s0_load || s1_load)         s0_vld_r  <= s0_load;
      if (s1_load || out_load)        s1_vld_r  <= s1_load;
      if (out_load || out_ch.ready)   out_vld_r <= out_load;
    end
  end

  // Capture the beat, arranging corners in perimeter order
  always_ff @(posedge clk) begin
    if (s0_load) begin
      s0_corners_r.px[0] <= in_ch.box_left;
      s0_corners_r.py[0] <= in_ch.box_top;
      s0_corners_r.px[1] <= in_ch.box_right;
      s0_corners_r.py[1] <= in_ch.box_top;
      s0_corners_r.px[2] <= in_ch.box_right;
      s0_corners_r.py[2] <= in_ch.box_bottom;
      s0_corners_r.px[3] <= in_ch.box_left;
      s0_corners_r.py[3] <= in_ch.box_bottom;
      s0_corners_r.qx[0] <= in_ch.quad_x0;
      s0_corners_r.qy[0] <= in_ch.quad_y0;
      s0_corners_r.qx[1] <= in_ch.quad_x1;
      s0_corners_r.qy[1] <= in_ch.quad_y1;
      s0_corners_r.qx[2] <= in_ch.quad_x3;
      s0_corners_r.qy[2] <= in_ch.quad_y3;
      s0_corners_r.qx[3] <= in_ch.quad_x2;
      s0_corners_r.qy[3] <= in_ch.quad_y2;
    end
  end

  bqsat_proj u_proj (
    .corners (s0_corners_r),
    .prods   (prods_nxt)
  );

  // Register the products
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_prods_r <= prods_nxt;
    end
  end

  bqsat_sep u_sep (
    .prods      (s1_prods_r),
    .intersects (int_nxt)
  );

  // Register the result
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_int_r <= int_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.intersects = out_int_r;

endmodule

/* rtl/core/bqsat_proj.sv */
// Edge normals of both shapes and their products with every corner.
`timescale 1ns / 1ps

module bqsat_proj (
  input  bqsat_pkg::corners_t  corners,
  output bqsat_pkg::prod_set_t prods
);

  bqsat_pkg::diff_t ax [bqsat_pkg::AXIS_COUNT];
  bqsat_pkg::diff_t ay [bqsat_pkg::AXIS_COUNT];

  // Form the perpendicular of each edge: (-(yj - yi), xj - xi)
  always_comb begin
    for (int i = 0; i < bqsat_pkg::VERTEX_COUNT; i++) begin
      ax[i] = bqsat_pkg::diff_t'(corners.py[i])
            - bqsat_pkg::diff_t'(corners.py[(i + 1) % bqsat_pkg::VERTEX_COUNT]);
      ay[i] = bqsat_pkg::diff_t'(corners.px[(i + 1) % bqsat_pkg::VERTEX_COUNT])
            - bqsat_pkg::diff_t'(corners.px[i]);
      ax[i + bqsat_pkg::VERTEX_COUNT] = bqsat_pkg::diff_t'(corners.qy[i])
            - bqsat_pkg::diff_t'(corners.qy[(i + 1) % bqsat_pkg::VERTEX_COUNT]);
      ay[i + bqsat_pkg::VERTEX_COUNT] =
              bqsat_pkg::diff_t'(corners.qx[(i + 1) % bqsat_pkg::VERTEX_COUNT])
            - bqsat_pkg::diff_t'(corners.qx[i]);
    end
  end

  // Multiply each axis's x and y components by the matching coordinate of every corner
  always_comb begin
    for (int a = 0; a < bqsat_pkg::AXIS_COUNT; a++) begin
      for (int v = 0; v < bqsat_pkg::VERTEX_COUNT; v++) begin
        prods.px[a][v] = bqsat_pkg::prod_t'(ax[a]) * bqsat_pkg::prod_t'(corners.px[v]);
        prods.py[a][v] = bqsat_pkg::prod_t'(ay[a]) * bqsat_pkg::prod_t'(corners.py[v]);
        prods.qx[a][v] = bqsat_pkg::prod_t'(ax[a]) * bqsat_pkg::prod_t'(corners.qx[v]);
        prods.qy[a][v] = bqsat_pkg::prod_t'(ay[a]) * bqsat_pkg::prod_t'(corners.qy[v]);
      end
    end
  end

endmodule

/* rtl/core/bqsat_sep.sv */
// Projection ranges per axis and the overall overlap decision.
`timescale 1ns / 1ps

module bqsat_sep (
  input  bqsat_pkg::prod_set_t prods,
  output logic                 intersects
);

  logic [bqsat_pkg::AXIS_COUNT-1:0] sep;

  // Sum products into dot values, track min and max, compare the ranges
  always_comb begin
    bqsat_pkg::dot_t dp;
    bqsat_pkg::dot_t dq;
    bqsat_pkg::dot_t pmin;
    bqsat_pkg::dot_t pmax;
    bqsat_pkg::dot_t qmin;
    bqsat_pkg::dot_t qmax;
    for (int a = 0; a < bqsat_pkg::AXIS_COUNT; a++) begin
      pmin = '0;
      pmax = '0;
      qmin = '0;
      qmax = '0;
      for (int v = 0; v < bqsat_pkg::VERTEX_COUNT; v++) begin
        dp = bqsat_pkg::dot_t'(prods.px[a][v]) + bqsat_pkg::dot_t'(prods.py[a][v]);
        dq = bqsat_pkg::dot_t'(prods.qx[a][v]) + bqsat_pkg::dot_t'(prods.qy[a][v]);
        if (v == 0 || dp < pmin) pmin = dp;
        if (v == 0 || dp > pmax) pmax = dp;
        if (v == 0 || dq < qmin) qmin = dq;
        if (v == 0 || dq > qmax) qmax = dq;
      end
      sep[a] = (pmax < qmin) || (qmax < pmin);
    end
  end

  // Touching ranges still count as overlap
  assign intersects = ~|sep;

endmodule

/* rtl/core/bqsat_checker.sv */
// Port-level checks of the separating-axis test and their binding.
`timescale 1ns / 1ps

module bqsat_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_intersects
);

  logic [2:0] occ_r;
  logic [2:0] occ_nxt;

  // Track items accepted but not yet delivered
  always_comb begin
    occ_nxt = occ_r;
    if (in_valid && in_ready)   occ_nxt = occ_nxt + 3'd1;
    if (out_valid && out_ready) occ_nxt = occ_nxt - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 3'd0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_intersects))
    else $error("stalled result changed");

  a_occ_limit: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 3'd3)
    else $error("more items in flight than pipeline stages");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == 3'd0 |-> in_ready && !out_valid)
    else $error("empty block refuses input or shows a result");

endmodule

bind box_quad_separating_axis_test_top bqsat_checker u_bqsat_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_intersects (out_ch.intersects)
);
